[hdl/smra_pkg.sv]
// shared types and constants for the spi master register access block
`default_nettype none
package smra_pkg;

   localparam int BYTE_BITS = 8;
   localparam int BIT_IDX_W = $clog2(BYTE_BITS);

   localparam logic OP_COMMAND = 1'b0;
   localparam logic OP_DATA    = 1'b1;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCK_HALF_PERIOD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_GAP     = 1'b1;

   localparam logic [BYTE_BITS-1:0] SCK_HALF_PERIOD_RESET = 8'd4;
   localparam logic [BYTE_BITS-1:0] COMMAND_GAP_RESET     = 8'd8;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [BYTE_BITS-1:0] byte_type;

   typedef struct packed {
      logic     is_cmd;
      byte_type tx_byte;
      logic     end_frame;
      byte_type miso_bits;
   } entry_type;

   typedef struct packed {
      byte_type sck_half_period;
      byte_type command_gap;
   } cfg_type;

endpackage
`default_nettype wire

[hdl/smra_front.sv]
// front stage: registers and classifies incoming items
`default_nettype none
module smra_front import smra_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_ready,
   input  wire logic      req_opcode,
   input  wire byte_type  req_tx_byte,
   input  wire logic      req_end_frame,
   input  wire byte_type  req_miso_bits,
   output logic           push,
   output entry_type      push_entry,
   input  wire logic      queue_ready
);

   logic      valid_ff, valid_in;
   entry_type entry_ff;

   assign push      = valid_ff && queue_ready;
   assign req_ready = !valid_ff || queue_ready;
   assign push_entry = entry_ff;

   always_comb begin
      valid_in = valid_ff && !queue_ready;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         entry_ff.is_cmd    <= (req_opcode == OP_COMMAND);
         entry_ff.tx_byte   <= req_tx_byte;
         entry_ff.end_frame <= req_end_frame;
         entry_ff.miso_bits <= req_miso_bits;
      end
   end

endmodule
`default_nettype wire

[hdl/smra_queue.sv]
// short item queue between front and back
`default_nettype none
module smra_queue import smra_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           queue_ready,
   input  wire logic      pop,
   output logic           q_valid,
   output entry_type      q_entry
);

   entry_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign queue_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign q_valid     = (count_ff != '0);
   assign q_entry     = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !queue_ready |-> !push) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !q_valid |-> !pop) else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

[hdl/smra_back.sv]
// back end: sck timing, byte shifter, command gap and result register
`default_nettype none
module smra_back import smra_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      q_valid,
   input  wire entry_type q_entry,
   output logic           pop,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output byte_type       rsp_rx_byte,
   output logic           rsp_is_status,
   output logic           rsp_frame_closed
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SHIFT = 2'd1;
   localparam logic [1:0] S_HOLD  = 2'd2;
   localparam logic [1:0] S_GAP   = 2'd3;

   logic [1:0]           state_ff, state_in;
   byte_type             cnt_ff, cnt_in;
   logic                 sck_ff, sck_in;
   logic [BIT_IDX_W-1:0] bit_ff, bit_in;
   byte_type             sr_ff, sr_in;
   byte_type             msr_ff, msr_in;
   logic                 is_cmd_ff, is_cmd_in;
   logic                 end_ff, end_in;
   byte_type             gap_ff, gap_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   byte_type             rsp_rx_ff;
   logic                 rsp_status_ff, rsp_closed_ff;

   byte_type half;
   logic     phase_end;
   logic     rsp_free;
   logic     deliver;
   logic     start_next;

   assign half      = (cfg.sck_half_period == '0) ? 8'd1 : cfg.sck_half_period;
   assign phase_end = (cnt_ff == half - 8'd1);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rx_byte      = rsp_rx_ff;
   assign rsp_is_status    = rsp_status_ff;
   assign rsp_frame_closed = rsp_closed_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sck_in       = sck_ff;
      bit_in       = bit_ff;
      sr_in        = sr_ff;
      msr_in       = msr_ff;
      is_cmd_in    = is_cmd_ff;
      end_in       = end_ff;
      gap_in       = gap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      deliver      = 1'b0;
      start_next   = 1'b0;
      pop          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               start_next = 1'b1;
            end
         end
         S_SHIFT: begin
            cnt_in = cnt_ff + 8'd1;
            if (phase_end) begin
               cnt_in = '0;
               if (sck_ff) begin
                  // falling edge: sample miso
                  sck_in = 1'b0;
                  sr_in  = {sr_ff[BYTE_BITS-2:0], msr_ff[BYTE_BITS-1]};
                  msr_in = {msr_ff[BYTE_BITS-2:0], 1'b0};
               end else if (bit_ff == BIT_IDX_W'(BYTE_BITS - 1)) begin
                  if (rsp_free) begin
                     deliver = 1'b1;
                  end else begin
                     state_in = S_HOLD;
                  end
               end else begin
                  bit_in = bit_ff + 1'b1;
                  sck_in = 1'b1;
               end
            end
         end
         S_HOLD: begin
            if (rsp_free) begin
               deliver = 1'b1;
            end
         end
         S_GAP: begin
            if (gap_ff == 8'd1) begin
               if (q_valid) begin
                  start_next = 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               gap_in = gap_ff - 8'd1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (deliver) begin
         rsp_valid_in = 1'b1;
         if (is_cmd_ff && (cfg.command_gap != '0)) begin
            state_in = S_GAP;
            gap_in   = cfg.command_gap;
         end else if (q_valid) begin
            start_next = 1'b1;
         end else begin
            state_in = S_IDLE;
         end
      end

      if (start_next) begin
         pop       = 1'b1;
         state_in  = S_SHIFT;
         cnt_in    = '0;
         sck_in    = 1'b1;
         bit_in    = '0;
         sr_in     = q_entry.tx_byte;
         msr_in    = q_entry.miso_bits;
         is_cmd_in = q_entry.is_cmd;
         end_in    = q_entry.end_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         sck_ff       <= 1'b0;
         bit_ff       <= '0;
         gap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sck_ff       <= sck_in;
         bit_ff       <= bit_in;
         gap_ff       <= gap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff     <= sr_in;
      msr_ff    <= msr_in;
      is_cmd_ff <= is_cmd_in;
      end_ff    <= end_in;
      if (deliver) begin
         rsp_rx_ff     <= sr_ff;
         rsp_status_ff <= is_cmd_ff;
         rsp_closed_ff <= end_ff;
      end
   end

`ifndef SYNTH
   a_idle_takes_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && q_valid) |-> pop) else $error("idle back end left item queued");
   a_sck_low_outside_shift: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_SHIFT) |-> !sck_ff) else $error("sck high outside a transfer");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      deliver |-> rsp_free) else $error("result register overwritten");
   a_gap_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GAP) |-> (gap_ff != '0)) else $error("gap counter ran past zero");
`endif

endmodule
`default_nettype wire

[hdl/spi_master_register_access.sv]
// top level of the spi master register access block
`default_nettype none
// Each item moves one byte as a mode 1 style SPI transfer, MSB first: SCK rises and MOSI
// takes the next bit, one half period later SCK falls and MISO is sampled. sck_half_period
// sets the half period (zero counts as one), counted by the SCK phase counter in the back
// end; a command byte is followed by an idle gap counted down from a nonzero command_gap
// before the next byte starts. The front register and two-item queue take new items while
// a byte is shifting. After a data byte, a queued item starts in the cycle after delivery,
// and delivery waits for a free result register. rx_byte is the byte shifted in, is_status
// marks a command byte, frame_closed an end flag.
module spi_master_register_access import smra_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_opcode,
   input  wire byte_type               req_tx_byte,
   input  wire logic                   req_end_frame,
   input  wire byte_type               req_miso_bits,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output byte_type                    rsp_rx_byte,
   output logic                        rsp_is_status,
   output logic                        rsp_frame_closed,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire byte_type               csr_wdata
);

   cfg_type   cfg_ff;
   logic      push, queue_ready, pop, q_valid;
   entry_type push_entry, q_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sck_half_period <= SCK_HALF_PERIOD_RESET;
         cfg_ff.command_gap     <= COMMAND_GAP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCK_HALF_PERIOD: cfg_ff.sck_half_period <= csr_wdata;
            CSR_COMMAND_GAP:     cfg_ff.command_gap     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   smra_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_tx_byte   (req_tx_byte),
      .req_end_frame (req_end_frame),
      .req_miso_bits (req_miso_bits),
      .push          (push),
      .push_entry    (push_entry),
      .queue_ready   (queue_ready)
   );

   smra_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_entry  (push_entry),
      .queue_ready (queue_ready),
      .pop         (pop),
      .q_valid     (q_valid),
      .q_entry     (q_entry)
   );

   smra_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rx_byte      (rsp_rx_byte),
      .rsp_is_status    (rsp_is_status),
      .rsp_frame_closed (rsp_frame_closed)
   );

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// self-checking testbench for the spi master register access block
module testbench import smra_pkg::*;;

   typedef struct packed {
      logic     opcode;
      byte_type tx_byte;
      logic     end_frame;
      byte_type miso_bits;
   } spi_req_type;

   typedef struct packed {
      byte_type rx_byte;
      logic     is_status;
      logic     frame_closed;
   } spi_rsp_type;

   typedef struct packed {
      spi_req_type req;
      logic        typed;
      spi_rsp_type rsp;
   } directed_row_type;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int DIRECTED_COUNT = 17;

   // typed rows carry their result, the others go through the predictor
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{'{OP_DATA,    8'h00, 1'b0, 8'hA5}, 1'b1, '{8'hA5, 1'b0, 1'b0}},
      '{'{OP_DATA,    8'hFF, 1'b1, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{'{OP_COMMAND, 8'h80, 1'b0, 8'hFF}, 1'b1, '{8'hFF, 1'b1, 1'b0}},
      '{'{OP_DATA,    8'hFF, 1'b0, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{'{OP_COMMAND, 8'h7F, 1'b0, 8'h5A}, 1'b0, '0},
      '{'{OP_DATA,    8'h00, 1'b0, 8'hFF}, 1'b1, '{8'hFF, 1'b0, 1'b0}},
      '{'{OP_DATA,    8'hAA, 1'b1, 8'h55}, 1'b0, '0},
      '{'{OP_COMMAND, 8'h3C, 1'b1, 8'hC3}, 1'b0, '0},
      '{'{OP_COMMAND, 8'h01, 1'b0, 8'h80}, 1'b0, '0},
      '{'{OP_DATA,    8'h00, 1'b0, 8'h01}, 1'b0, '0},
      '{'{OP_DATA,    8'h55, 1'b0, 8'hAA}, 1'b0, '0},
      '{'{OP_DATA,    8'hFF, 1'b1, 8'hFF}, 1'b1, '{8'hFF, 1'b0, 1'b1}},
      '{'{OP_COMMAND, 8'h00, 1'b1, 8'h00}, 1'b1, '{8'h00, 1'b1, 1'b1}},
      '{'{OP_COMMAND, 8'hFF, 1'b0, 8'h7E}, 1'b0, '0},
      '{'{OP_COMMAND, 8'h0F, 1'b0, 8'hF0}, 1'b0, '0},
      '{'{OP_DATA,    8'hF0, 1'b1, 8'h0F}, 1'b0, '0},
      '{'{OP_DATA,    8'h12, 1'b1, 8'h34}, 1'b0, '0}
   };

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic                   req_opcode       = OP_COMMAND;
   byte_type               req_tx_byte      = '0;
   logic                   req_end_frame    = 1'b0;
   byte_type               req_miso_bits    = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   byte_type               rsp_rx_byte;
   logic                   rsp_is_status;
   logic                   rsp_frame_closed;
   logic                   csr_we           = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = CSR_SCK_HALF_PERIOD;
   byte_type               csr_wdata        = '0;

   spi_rsp_type awaited_bytes [$];
   cfg_type  cfg_shadow         = '{SCK_HALF_PERIOD_RESET, COMMAND_GAP_RESET};
   logic     cs_active          = 1'b0;
   int       error_count        = 0;
   int       idle_cycles        = 0;
   int       hold_left          = 0;
   int       sender_idle_pct    = 0;
   int       receiver_stall_pct = 0;

   spi_master_register_access i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_tx_byte      (req_tx_byte),
      .req_end_frame    (req_end_frame),
      .req_miso_bits    (req_miso_bits),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rx_byte      (rsp_rx_byte),
      .rsp_is_status    (rsp_is_status),
      .rsp_frame_closed (rsp_frame_closed),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic spi_rsp_type predict_transfer(spi_req_type r);
      spi_rsp_type p;
      byte_type shreg;
      shreg = r.tx_byte;
      for (int i = 0; i < BYTE_BITS; i++) begin
         shreg = {shreg[BYTE_BITS-2:0], r.miso_bits[BYTE_BITS-1-i]};
      end
      cs_active = !r.end_frame;
      p.rx_byte = shreg;
      p.is_status = (r.opcode == OP_COMMAND);
      p.frame_closed = r.end_frame;
      return p;
   endfunction

   // mostly well-formed frames, some random noise
   function automatic spi_req_type next_random_req();
      spi_req_type r;
      r.tx_byte = byte_type'($urandom_range(255));
      r.miso_bits = byte_type'($urandom_range(255));
      if ($urandom_range(99) < 15) begin
         r.opcode = 1'($urandom_range(1));
         r.end_frame = 1'($urandom_range(1));
      end else if (!cs_active) begin
         r.opcode = OP_COMMAND;
         r.end_frame = ($urandom_range(7) == 0);
      end else begin
         r.opcode = OP_DATA;
         r.end_frame = ($urandom_range(2) == 0);
         if ($urandom_range(3) == 0) r.tx_byte = '0;
      end
      return r;
   endfunction

   function automatic int settle_cycles();
      return int'(cfg_shadow.command_gap) + 16;
   endfunction

   task automatic send_byte(input spi_req_type r, input logic typed,
                            input spi_rsp_type typed_rsp);
      spi_rsp_type p;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= r.opcode;
      req_tx_byte <= r.tx_byte;
      req_end_frame <= r.end_frame;
      req_miso_bits <= r.miso_bits;
      do @(posedge clock); while (!req_ready);
      p = predict_transfer(r);
      awaited_bytes.push_back(typed ? typed_rsp : p);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_bytes.size() != 0);
      repeat (settle_cycles()) @(posedge clock);
   endtask

   task automatic set_config(input byte_type half_period, input byte_type gap);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_SCK_HALF_PERIOD;
      csr_wdata <= half_period;
      @(posedge clock);
      csr_index <= CSR_COMMAND_GAP;
      csr_wdata <= gap;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_shadow = '{half_period, gap};
   endtask

   task automatic run_random(input int count, input int send_pct, input int stall_pct,
                             input int pause_at);
      sender_idle_pct = send_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         if (n == pause_at) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (awaited_bytes.size() != 0);
         end
         send_byte(next_random_req(), 1'b0, '0);
      end
   endtask

   task automatic log_mismatch(input string what, input spi_rsp_type want,
                               input spi_rsp_type got);
      error_count++;
      if (error_count <= 10)
         $display("%s: expected rx %02h status %0b closed %0b, got rx %02h status %0b closed %0b",
                  what, want.rx_byte, want.is_status, want.frame_closed,
                  got.rx_byte, got.is_status, got.frame_closed);
   endtask

   always @(posedge clock) begin : rsp_check
      spi_rsp_type want;
      spi_rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_rx_byte, rsp_is_status, rsp_frame_closed};
         if (awaited_bytes.size() == 0) begin
            log_mismatch("item with nothing pending", '0, got);
         end else begin
            want = awaited_bytes.pop_front();
            if (got !== want) log_mismatch("item mismatch", want, got);
         end
      end
   end

   // receiver backpressure, with a long hold-off while hold_left counts down
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < DIRECTED_COUNT; n++) begin
         send_byte(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].rsp);
      end

      set_config(8'd1, 8'd0);
      run_random(250, 0, 0, -1);

      // zero half period counts as one
      set_config(8'd0, 8'd255);
      run_random(120, 87, 0, 60);

      set_config(8'd2, 8'd3);
      hold_left = 800;
      run_random(200, 0, 87, -1);

      set_config(8'd1, 8'd1);
      run_random(200, 28, 28, 100);

      set_config(8'd255, 8'd255);
      run_random(12, 28, 28, -1);

      drain();
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[files.f]
hdl/smra_pkg.sv
hdl/smra_front.sv
hdl/smra_queue.sv
hdl/smra_back.sv
hdl/spi_master_register_access.sv
tb/sv/testbench.sv
